### rtl/fpp_pkg.sv
// Shared types, character codes and decode helpers for the position text parser.
// No dependencies; every other file of the block but fpp_chk uses this package.
package fpp_pkg;

    // Parser section, in text order
    typedef enum logic [2:0] {
        SEC_PLACE    = 3'd0,
        SEC_TURN     = 3'd1,
        SEC_CASTLE   = 3'd2,
        SEC_PASSANT  = 3'd3,
        SEC_HALFMOVE = 3'd4,
        SEC_FULLMOVE = 3'd5
    } t_section;

    // Board slots: two color boards, then six piece-type boards
    localparam int unsigned NUM_BOARDS = 8;
    localparam logic [2:0] BD_WHITE  = 3'd0;
    localparam logic [2:0] BD_BLACK  = 3'd1;
    localparam logic [2:0] BD_PAWN   = 3'd2;
    localparam logic [2:0] BD_KNIGHT = 3'd3;
    localparam logic [2:0] BD_BISHOP = 3'd4;
    localparam logic [2:0] BD_ROOK   = 3'd5;
    localparam logic [2:0] BD_QUEEN  = 3'd6;
    localparam logic [2:0] BD_KING   = 3'd7;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ONE    = 8'd49;
    localparam logic [7:0] CH_EIGHT  = 8'd56;
    localparam logic [7:0] CH_LOW_A  = 8'd97;
    localparam logic [7:0] CH_LOW_H  = 8'd104;
    localparam logic [7:0] CH_UP_K   = 8'h4B;
    localparam logic [7:0] CH_UP_Q   = 8'h51;
    localparam logic [7:0] CH_LOW_K  = 8'h6B;
    localparam logic [7:0] CH_LOW_Q  = 8'h71;
    localparam logic [7:0] CH_LOW_W  = 8'h77;
    localparam logic [7:0] CH_LOW_B  = 8'h62;

    // Reset values of the parser state
    localparam logic [2:0] RANK_TOP     = 3'd7;
    localparam logic [3:0] RIGHTS_INIT  = 4'hF;
    localparam logic [6:0] SQUARE_NONE  = 7'd64;

    // Decoded piece letter
    typedef struct packed {
        logic       valid;
        logic [2:0] color;
        logic [2:0] kind;
    } t_piece;

    // One result beat
    typedef struct packed {
        logic [63:0] white_board;
        logic [63:0] black_board;
        logic [63:0] pawn_board;
        logic [63:0] knight_board;
        logic [63:0] bishop_board;
        logic [63:0] rook_board;
        logic [63:0] queen_board;
        logic [63:0] king_board;
        logic        side_to_move;
        logic [3:0]  castling_mask;
        logic [6:0]  passant_square;
        logic        status;
    } t_result;

    // Core to result register: result present this cycle, and its payload
    typedef struct packed {
        logic    emit;
        t_result res;
    } t_core_out;

    // Map a piece letter to its color and type board
    function automatic t_piece piece_decode(input logic [7:0] ch);
        t_piece p;
        p.valid = 1'b1;
        p.color = (ch >= 8'h61 && ch <= 8'h7A) ? BD_BLACK : BD_WHITE;
        case (ch)
            8'h50, 8'h70: p.kind = BD_PAWN;
            8'h4E, 8'h6E: p.kind = BD_KNIGHT;
            8'h42, 8'h62: p.kind = BD_BISHOP;
            8'h52, 8'h72: p.kind = BD_ROOK;
            8'h51, 8'h71: p.kind = BD_QUEEN;
            8'h4B, 8'h6B: p.kind = BD_KING;
            default: begin
                p.valid = 1'b0;
                p.kind  = BD_PAWN;
            end
        endcase
        return p;
    endfunction

endpackage

### rtl/fen_position_parser.sv
// Position text parser: one character per beat, one result per finished or bad position.
// An accepted character is held in the input register; the result it ends is then loaded into the result register.
// Throughput: one character per cycle; the input register stalls only when a character
// that ends a position meets a full result register whose beat is stalled.
// Reset (i_rst_n low, synchronous): parser back to placement, boards cleared, no result.
// Depends on fpp_pkg, fpp_core and fpp_out.
module fen_position_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_fen_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_white_board,
    output logic [63:0] o_black_board,
    output logic [63:0] o_pawn_board,
    output logic [63:0] o_knight_board,
    output logic [63:0] o_bishop_board,
    output logic [63:0] o_rook_board,
    output logic [63:0] o_queen_board,
    output logic [63:0] o_king_board,
    output logic        o_side_to_move,
    output logic [3:0]  o_castling_mask,
    output logic [6:0]  o_passant_square,
    output logic        o_status
);

    logic               r_in_vld, n_in_vld;
    logic [7:0]         r_in_char;
    logic               in_accept;
    logic               advance;
    logic               fire;
    fpp_pkg::t_core_out core;
    fpp_pkg::t_result   res;

    // Process the held character unless its result has nowhere to go
    assign advance   = !core.emit || !o_valid || !i_stall;
    assign fire      = r_in_vld && advance;
    assign o_stall   = r_in_vld && !advance;
    assign in_accept = i_valid && !o_stall;

    // Input register
    always_comb begin
        n_in_vld = r_in_vld;
        if (in_accept) begin
            n_in_vld = 1'b1;
        end else if (fire) begin
            n_in_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= i_fen_char;
        end
    end

    fpp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (r_in_char),
        .o_core  (core)
    );

    fpp_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && core.emit),
        .i_res   (core.res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (res)
    );

    // Unpack the result beat onto the ports
    assign o_white_board    = res.white_board;
    assign o_black_board    = res.black_board;
    assign o_pawn_board     = res.pawn_board;
    assign o_knight_board   = res.knight_board;
    assign o_bishop_board   = res.bishop_board;
    assign o_rook_board     = res.rook_board;
    assign o_queen_board    = res.queen_board;
    assign o_king_board     = res.king_board;
    assign o_side_to_move   = res.side_to_move;
    assign o_castling_mask  = res.castling_mask;
    assign o_passant_square = res.passant_square;
    assign o_status         = res.status;

endmodule

### rtl/fpp_core.sv
// Parser state and per-character update: sections, rank/file counters, boards.
// Depends on fpp_pkg.
module fpp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_char,
    output fpp_pkg::t_core_out o_core
);

    fpp_pkg::t_section r_section, n_section;
    logic [2:0]        r_rank, n_rank;
    logic [2:0]        r_file, n_file;
    logic [63:0]       r_boards [fpp_pkg::NUM_BOARDS];
    logic [63:0]       n_boards [fpp_pkg::NUM_BOARDS];
    logic              r_turn, n_turn;
    logic [3:0]        r_rights, n_rights;
    logic [3:0]        r_ep_file, n_ep_file;
    logic [3:0]        r_ep_rank, n_ep_rank;

    fpp_pkg::t_piece   piece;
    logic [63:0]       sq_bit;
    logic              is_digit;
    logic              is_sep;
    logic              emit;
    logic              bad;
    logic              restart;
    logic [3:0]        ep_file_m1;
    logic [3:0]        ep_rank_m1;

    assign piece    = fpp_pkg::piece_decode(i_char);
    assign sq_bit   = 64'd1 << {r_rank, r_file};
    assign is_digit = (i_char >= fpp_pkg::CH_ONE) && (i_char <= fpp_pkg::CH_EIGHT);
    assign is_sep   = (i_char == fpp_pkg::CH_SLASH) || (i_char == fpp_pkg::CH_SPACE);

    // Decode the character against the current section
    always_comb begin
        n_section = r_section;
        n_rank    = r_rank;
        n_file    = r_file;
        n_turn    = r_turn;
        n_rights  = r_rights;
        n_ep_file = r_ep_file;
        n_ep_rank = r_ep_rank;
        for (int b = 0; b < fpp_pkg::NUM_BOARDS; b++) begin
            n_boards[b] = r_boards[b];
        end
        emit    = 1'b0;
        bad     = 1'b0;
        restart = 1'b0;

        unique case (r_section)
            fpp_pkg::SEC_PLACE: begin
                if (is_digit) begin
                    // '1'..'8' low bits give the value mod 8
                    n_file = r_file + i_char[2:0];
                end else if (is_sep) begin
                    if (r_rank == 3'd0) begin
                        n_rank    = fpp_pkg::RANK_TOP;
                        n_section = fpp_pkg::SEC_TURN;
                    end else begin
                        n_rank = r_rank - 3'd1;
                    end
                end else if (piece.valid) begin
                    n_boards[piece.color] = r_boards[piece.color] | sq_bit;
                    n_boards[piece.kind]  = r_boards[piece.kind] | sq_bit;
                    n_file = r_file + 3'd1;
                end else begin
                    emit    = 1'b1;
                    bad     = 1'b1;
                    restart = 1'b1;
                end
            end
            fpp_pkg::SEC_TURN: begin
                if (i_char == fpp_pkg::CH_LOW_W) begin
                    n_turn = 1'b0;
                end else if (i_char == fpp_pkg::CH_LOW_B) begin
                    n_turn = 1'b1;
                end else if (i_char == fpp_pkg::CH_SPACE) begin
                    n_section = fpp_pkg::SEC_CASTLE;
                end
            end
            fpp_pkg::SEC_CASTLE: begin
                if (i_char == fpp_pkg::CH_UP_K) begin
                    n_rights = r_rights ^ 4'b0001;
                end else if (i_char == fpp_pkg::CH_UP_Q) begin
                    n_rights = r_rights ^ 4'b0010;
                end else if (i_char == fpp_pkg::CH_LOW_K) begin
                    n_rights = r_rights ^ 4'b0100;
                end else if (i_char == fpp_pkg::CH_LOW_Q) begin
                    n_rights = r_rights ^ 4'b1000;
                end else if (i_char == fpp_pkg::CH_SPACE) begin
                    n_section = fpp_pkg::SEC_PASSANT;
                end
            end
            fpp_pkg::SEC_PASSANT: begin
                // Letters a..h and digits 1..8 both carry file/rank + 1 in bits 3:0
                if (i_char >= fpp_pkg::CH_LOW_A && i_char <= fpp_pkg::CH_LOW_H) begin
                    n_ep_file = i_char[3:0];
                end else if (is_digit) begin
                    n_ep_rank = i_char[3:0];
                end else if (i_char == fpp_pkg::CH_SPACE) begin
                    n_section = fpp_pkg::SEC_HALFMOVE;
                end
            end
            fpp_pkg::SEC_HALFMOVE: begin
                if (i_char == fpp_pkg::CH_SPACE) begin
                    n_section = fpp_pkg::SEC_FULLMOVE;
                end
            end
            fpp_pkg::SEC_FULLMOVE: begin
                if (i_char == fpp_pkg::CH_SPACE || i_char == fpp_pkg::CH_LF ||
                    i_char == fpp_pkg::CH_NUL) begin
                    emit    = 1'b1;
                    restart = 1'b1;
                end
            end
            default: begin
                restart = 1'b1;
            end
        endcase

        // Start over on a new position
        if (restart) begin
            n_section = fpp_pkg::SEC_PLACE;
            n_rank    = fpp_pkg::RANK_TOP;
            n_file    = 3'd0;
            n_turn    = 1'b0;
            n_rights  = fpp_pkg::RIGHTS_INIT;
            n_ep_file = 4'd0;
            n_ep_rank = 4'd0;
            for (int b = 0; b < fpp_pkg::NUM_BOARDS; b++) begin
                n_boards[b] = 64'd0;
            end
        end
    end

    // Build the result beat from the state before this character
    assign ep_file_m1 = r_ep_file - 4'd1;
    assign ep_rank_m1 = r_ep_rank - 4'd1;

    always_comb begin
        o_core      = '0;
        o_core.emit = emit;
        if (bad) begin
            o_core.res.status = 1'b1;
        end else begin
            o_core.res.white_board   = r_boards[fpp_pkg::BD_WHITE];
            o_core.res.black_board   = r_boards[fpp_pkg::BD_BLACK];
            o_core.res.pawn_board    = r_boards[fpp_pkg::BD_PAWN];
            o_core.res.knight_board  = r_boards[fpp_pkg::BD_KNIGHT];
            o_core.res.bishop_board  = r_boards[fpp_pkg::BD_BISHOP];
            o_core.res.rook_board    = r_boards[fpp_pkg::BD_ROOK];
            o_core.res.queen_board   = r_boards[fpp_pkg::BD_QUEEN];
            o_core.res.king_board    = r_boards[fpp_pkg::BD_KING];
            o_core.res.side_to_move  = r_turn;
            o_core.res.castling_mask = r_rights;
            if (r_ep_file != 4'd0 && r_ep_rank != 4'd0) begin
                o_core.res.passant_square = {1'b0, ep_rank_m1[2:0], ep_file_m1[2:0]};
            end else begin
                o_core.res.passant_square = fpp_pkg::SQUARE_NONE;
            end
            o_core.res.status = 1'b0;
        end
    end

    // Advance the state on each processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section <= fpp_pkg::SEC_PLACE;
            r_rank    <= fpp_pkg::RANK_TOP;
            r_file    <= 3'd0;
            r_turn    <= 1'b0;
            r_rights  <= fpp_pkg::RIGHTS_INIT;
            r_ep_file <= 4'd0;
            r_ep_rank <= 4'd0;
            for (int b = 0; b < fpp_pkg::NUM_BOARDS; b++) begin
                r_boards[b] <= 64'd0;
            end
        end else if (i_fire) begin
            r_section <= n_section;
            r_rank    <= n_rank;
            r_file    <= n_file;
            r_turn    <= n_turn;
            r_rights  <= n_rights;
            r_ep_file <= n_ep_file;
            r_ep_rank <= n_ep_rank;
            for (int b = 0; b < fpp_pkg::NUM_BOARDS; b++) begin
                r_boards[b] <= n_boards[b];
            end
        end
    end

endmodule

### rtl/fpp_out.sv
// Result register: holds one result beat until the downstream side takes it.
// Depends on fpp_pkg.
module fpp_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  fpp_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_valid,
    output fpp_pkg::t_result o_res
);

    logic             r_vld, n_vld;
    fpp_pkg::t_result r_res;

    // Fill on load, drain when the beat is taken
    always_comb begin
        n_vld = r_vld;
        if (i_load) begin
            n_vld = 1'b1;
        end else if (r_vld && !i_stall) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule

### rtl/fpp_chk.sv
// Port-level checks for the position text parser, bound to the top level.
// Depends only on the ports of fen_position_parser.
module fpp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_fen_char,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_white_board,
    input logic [63:0] o_black_board,
    input logic [63:0] o_pawn_board,
    input logic [63:0] o_knight_board,
    input logic [63:0] o_bishop_board,
    input logic [63:0] o_rook_board,
    input logic [63:0] o_queen_board,
    input logic [63:0] o_king_board,
    input logic        o_side_to_move,
    input logic [3:0]  o_castling_mask,
    input logic [6:0]  o_passant_square,
    input logic        o_status
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_white_board) &&
        $stable(o_king_board) && $stable(o_status) && $stable(o_passant_square))
        else $error("stalled result beat changed");

    // Input stalls only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    // An error beat carries nothing but its status
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_white_board == 64'd0 && o_black_board == 64'd0 &&
        o_pawn_board == 64'd0 && o_king_board == 64'd0 && o_side_to_move == 1'b0 &&
        o_castling_mask == 4'd0 && o_passant_square == 7'd0)
        else $error("error beat carries board data");

    // Color and piece-type boards cover the same squares, and the passant square is at most 64
    a_board_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_status |-> (o_white_board | o_black_board) ==
        (o_pawn_board | o_knight_board | o_bishop_board | o_rook_board |
         o_queen_board | o_king_board) && o_passant_square <= 7'd64)
        else $error("inconsistent position beat");

endmodule

bind fen_position_parser fpp_chk u_fpp_chk (.*);
